@@ rtl/bicycle_odometry_integrator_assert.svh @@
// Assertion macros for the odometry integrator.
// Needs no other file; included by the modules that check themselves.
`ifndef BICYCLE_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define BICYCLE_ODOMETRY_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define BODO_ASSERT_SAME(label, ck, rn, ante, cons) \
label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bodo: same-cycle check failed");

// next-cycle implication
`define BODO_ASSERT_NEXT(label, ck, rn, ante, cons) \
label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bodo: next-cycle check failed");

`endif

@@ rtl/bodo_pkg.sv @@
// Shared types, constants and tables of the odometry integrator.
// No dependencies; used by every RTL module of the block.
`default_nettype none
package bodo_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int TABLE_LEN         = 24;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 40;

    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 176;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CPM       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP   = 2'd2;

    localparam logic [13:0] WHEELBASE_RST = 14'd700;
    localparam logic [19:0] CPM_RST       = 20'd33000;
    localparam logic [26:0] MAX_GAP_RST   = 27'd10000000;

    localparam logic [30:0] GAIN_Q30    = 31'd652032874;
    localparam logic [31:0] INV2PI_Q32  = 32'd683565276;
    localparam logic [63:0] DH_LIMIT    = 64'h4000_0000_0000_0000;
    localparam logic [30:0] DIST_LIMIT  = 31'h7FFF_FFFF;
    localparam logic [10:0] STEER_LIMIT = 11'd850;
    localparam logic [11:0] TENTHS_TURN = 12'd3600;
    localparam logic [10:0] TENTHS_HALF = 11'd1800;
    localparam logic [19:0] US_PER_S    = 20'd1000000;
    localparam logic [19:0] YAW_MUL     = 20'd15625;
    localparam logic [9:0]  MM_PER_M    = 10'd1000;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bicycle_odometry_integrator.sv @@
// Bicycle-model dead-reckoning integrator: sequencer, pose state and config registers.
// Depends on bodo_pkg, bodo_div, bodo_cordic and the assertion macro header.
//
// One report is taken at a time. A report whose time gap lies outside the window
// gives its result in the cycle after the transfer. An integrated report runs through
// up to ten passes of the shared divider and two passes of the CORDIC; a report with
// zero distance or zero steering skips three divider passes and one CORDIC pass.
// s_tready stays low from the transfer until the result has been taken.
`default_nettype none
`include "bicycle_odometry_integrator_assert.svh"
module bicycle_odometry_integrator
#(
    parameter int CORDIC_STEPS  = bodo_pkg::CORDIC_STEPS_DEF,
    parameter int POS_FRAC_BITS = bodo_pkg::POS_FRAC_BITS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // stamp_us[62:0], steer_tenths_deg[73:63], speed_counts[97:74], zero fill
    input  wire logic [bodo_pkg::IN_DATA_W-1:0]      s_tdata,
    // steer_present[0], speed_present[1]
    input  wire logic [bodo_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // pos_x[31:0], pos_y[63:32], heading_angle[79:64], vel_x[111:80],
    // vel_y[143:112], yaw_rate[175:144]
    output logic [bodo_pkg::OUT_DATA_W-1:0]          m_tdata,
    // updated[0]
    output logic [0:0]                               m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bodo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bodo_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int SHL = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;
    localparam int SHR = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DIST = 5'd1;
    localparam logic [4:0] ST_PH   = 5'd2;
    localparam logic [4:0] ST_ROT1 = 5'd3;
    localparam logic [4:0] ST_TAN  = 5'd4;
    localparam logic [4:0] ST_MUL1 = 5'd5;
    localparam logic [4:0] ST_MUL2 = 5'd6;
    localparam logic [4:0] ST_WB   = 5'd7;
    localparam logic [4:0] ST_MQ1  = 5'd8;
    localparam logic [4:0] ST_MQ2  = 5'd9;
    localparam logic [4:0] ST_DH   = 5'd10;
    localparam logic [4:0] ST_X0   = 5'd11;
    localparam logic [4:0] ST_ROT2 = 5'd12;
    localparam logic [4:0] ST_POSE = 5'd13;
    localparam logic [4:0] ST_SCL  = 5'd14;
    localparam logic [4:0] ST_SCQ  = 5'd15;
    localparam logic [4:0] ST_SCM  = 5'd16;
    localparam logic [4:0] ST_SCR  = 5'd17;
    localparam logic [4:0] ST_OUT  = 5'd18;

    localparam logic [1:0] K_VX = 2'd0;
    localparam logic [1:0] K_VY = 2'd1;
    localparam logic [1:0] K_YR = 2'd2;

    function automatic logic [31:0] sat_res(input logic neg, input logic [63:0] res);
        logic [31:0] v;
        if (neg)
        begin
            v = (res >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - res);
        end
        else
        begin
            v = (res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : res[31:0];
        end
        return v;
    endfunction

    logic [4:0]  state_reg, state_next;
    logic [13:0] wb_reg;
    logic [19:0] cpm_reg;
    logic [26:0] gap_reg;
    logic [62:0] last_reg, last_next;
    logic        upd_reg, upd_next;

    logic signed [10:0] a_reg, a_next;
    logic [23:0] cmag_reg, cmag_next;
    logic        cneg_reg, cneg_next;
    logic [26:0] dt_reg, dt_next;
    logic [30:0] dmag_reg, dmag_next;
    logic        sneg_reg, sneg_next;
    logic [23:0] tmag_reg, tmag_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic signed [63:0] dh_reg, dh_next;
    logic signed [33:0] dx_reg, dx_next;
    logic signed [33:0] dy_reg, dy_next;
    logic [1:0]  k_reg, k_next;
    logic [30:0] sq_reg, sq_next;
    logic [39:0] sr_reg, sr_next;
    logic [63:0] qm_reg, qm_next;

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic [15:0] head_reg, head_next;
    logic [31:0] vx_reg, vx_next;
    logic [31:0] vy_reg, vy_next;
    logic [31:0] yr_reg, yr_next;

    logic        div_start_reg, div_start_next;
    logic [63:0] div_a_reg, div_a_next;
    logic [39:0] div_b_reg, div_b_next;
    logic        cor_start_reg, cor_start_next;
    logic [31:0] cor_phase_reg, cor_phase_next;
    logic signed [63:0] cor_x0_reg, cor_x0_next;

    bodo_pkg::unit_stat_t div_stat;
    bodo_pkg::unit_stat_t cor_stat;
    logic [63:0] div_q;
    logic [39:0] div_r;
    logic signed [63:0] cor_cs;
    logic signed [63:0] cor_sn;

    logic [62:0] in_stamp;
    logic signed [10:0] in_steer;
    logic signed [23:0] in_speed;
    logic signed [10:0] a_in;
    logic signed [23:0] c_in;
    logic [62:0] gap_in;
    logic        upd_in;
    logic [19:0] cpm_eff;
    logic [13:0] wb_eff;
    logic [9:0]  amag;
    logic [30:0] dmag_now;
    logic [31:0] ph;
    logic signed [63:0] c_clamp;
    logic [63:0] s_mag;
    logic [63:0] lo_prod;
    logic [63:0] t_sh;
    logic [63:0] t_lim;
    logic signed [31:0] dist32;
    logic signed [63:0] x_dx;
    logic signed [63:0] y_dy;
    logic signed [34:0] x_sum;
    logic signed [34:0] y_sum;
    logic signed [63:0] hstep;
    logic signed [63:0] sc_val;
    logic        sc_neg;
    logic [63:0] sc_mag;
    logic [19:0] sc_mul;
    logic [39:0] sc_div;
    logic [63:0] sc_res;
    logic        sc_fin;
    logic [31:0] sc_out;

    bodo_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .stat     (div_stat),
        .quot     (div_q),
        .rem      (div_r)
    );

    bodo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start_reg),
        .phase (cor_phase_reg),
        .x0    (cor_x0_reg),
        .stat  (cor_stat),
        .cs    (cor_cs),
        .sn    (cor_sn)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == ST_IDLE;
    assign m_tvalid  = state_reg == ST_OUT;
    assign m_tdata   = {yr_reg, vy_reg, vx_reg, head_reg, y_reg, x_reg};
    assign m_tuser   = upd_reg;

    always_comb
    begin
        in_stamp = s_tdata[62:0];
        in_steer = s_tdata[73:63];
        in_speed = s_tdata[97:74];
        a_in = s_tuser[0] ? in_steer : 11'sd0;
        if (a_in > $signed(bodo_pkg::STEER_LIMIT))
        begin
            a_in = $signed(bodo_pkg::STEER_LIMIT);
        end
        else if (a_in < -$signed(bodo_pkg::STEER_LIMIT))
        begin
            a_in = -$signed(bodo_pkg::STEER_LIMIT);
        end
        c_in    = s_tuser[1] ? in_speed : 24'sd0;
        gap_in  = in_stamp - last_reg;
        upd_in  = (in_stamp > last_reg) && (gap_in < {36'd0, gap_reg});
        cpm_eff = (cpm_reg == '0) ? 20'd1 : cpm_reg;
        wb_eff  = (wb_reg == '0) ? 14'd1 : wb_reg;
        amag    = a_reg[10] ? 10'(-a_reg) : a_reg[9:0];

        dmag_now = (div_q > {33'd0, bodo_pkg::DIST_LIMIT}) ? bodo_pkg::DIST_LIMIT
                                                            : div_q[30:0];
        ph       = a_reg[10] ? 32'd0 - div_q[31:0] : div_q[31:0];
        c_clamp  = (cor_cs < 64'sd1) ? 64'sd1 : cor_cs;
        s_mag    = cor_sn[63] ? 64'(-cor_sn) : 64'(cor_sn);
        lo_prod  = prod_reg[31:0] * bodo_pkg::INV2PI_Q32;

        if (POS_FRAC_BITS < 16)
        begin
            t_sh = (acc_reg > (bodo_pkg::DH_LIMIT >> SHL)) ? bodo_pkg::DH_LIMIT
                                                          : acc_reg << SHL;
        end
        else
        begin
            t_sh = acc_reg >> SHR;
        end
        t_lim = (t_sh > bodo_pkg::DH_LIMIT) ? bodo_pkg::DH_LIMIT : t_sh;

        dist32 = cneg_reg ? -$signed({1'b0, dmag_reg}) : $signed({1'b0, dmag_reg});
        x_dx   = cor_cs + 64'sh2000_0000;
        y_dy   = cor_sn + 64'sh2000_0000;
        x_sum  = 35'(x_reg) + 35'(dx_reg);
        y_sum  = 35'(y_reg) + 35'(dy_reg);
        hstep  = dh_reg + 64'sd32768;

        case (k_reg)
            K_VX:    sc_val = 64'(dx_reg);
            K_VY:    sc_val = 64'(dy_reg);
            default: sc_val = dh_reg;
        endcase
        sc_neg = sc_val[63];
        sc_mag = sc_neg ? 64'(-sc_val) : 64'(sc_val);
        sc_mul = (k_reg == K_YR) ? bodo_pkg::YAW_MUL : bodo_pkg::US_PER_S;
        sc_div = (k_reg == K_YR) ? {3'd0, dt_reg, 10'd0} : {13'd0, dt_reg};
        sc_res = '0;
        sc_fin = 1'b0;
        if (state_reg == ST_SCQ && div_stat.done && div_q[63:31] != '0)
        begin
            sc_res = 64'h8000_0000;
            sc_fin = 1'b1;
        end
        else if (state_reg == ST_SCR && div_stat.done)
        begin
            sc_res = qm_reg + div_q;
            sc_fin = 1'b1;
        end
        sc_out = sat_res(sc_neg, sc_res);
    end

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        upd_next       = upd_reg;
        a_next         = a_reg;
        cmag_next      = cmag_reg;
        cneg_next      = cneg_reg;
        dt_next        = dt_reg;
        dmag_next      = dmag_reg;
        sneg_next      = sneg_reg;
        tmag_next      = tmag_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        dh_next        = dh_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        k_next         = k_reg;
        sq_next        = sq_reg;
        sr_next        = sr_reg;
        qm_next        = qm_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        head_next      = head_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        yr_next        = yr_reg;
        div_start_next = 1'b0;
        div_a_next     = div_a_reg;
        div_b_next     = div_b_reg;
        cor_start_next = 1'b0;
        cor_phase_next = cor_phase_reg;
        cor_x0_next    = cor_x0_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    last_next = in_stamp;
                    upd_next  = upd_in;
                    a_next    = a_in;
                    cneg_next = c_in[23];
                    cmag_next = c_in[23] ? 24'(-c_in) : c_in[23:0];
                    dt_next   = gap_in[26:0];
                    if (upd_in)
                    begin
                        div_start_next = 1'b1;
                        div_a_next     = ({40'd0, cmag_next} << POS_FRAC_BITS)
                                         + {45'd0, cpm_eff[19:1]};
                        div_b_next     = {20'd0, cpm_eff};
                        state_next     = ST_DIST;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIST:
            begin
                if (div_stat.done)
                begin
                    dmag_next = dmag_now;
                    dh_next   = '0;
                    if (a_reg != 11'sd0 && dmag_now != '0)
                    begin
                        div_start_next = 1'b1;
                        div_a_next     = {22'd0, amag, 32'd0} + {53'd0, bodo_pkg::TENTHS_HALF};
                        div_b_next     = {28'd0, bodo_pkg::TENTHS_TURN};
                        state_next     = ST_PH;
                    end
                    else
                    begin
                        state_next = ST_X0;
                    end
                end
            end
            ST_PH:
            begin
                if (div_stat.done)
                begin
                    cor_start_next = 1'b1;
                    cor_phase_next = ph;
                    cor_x0_next    = 64'sh4000_0000;
                    state_next     = ST_ROT1;
                end
            end
            ST_ROT1:
            begin
                if (cor_stat.done)
                begin
                    sneg_next      = cor_sn[63];
                    div_start_next = 1'b1;
                    div_a_next     = s_mag << 16;
                    div_b_next     = c_clamp[39:0];
                    state_next     = ST_TAN;
                end
            end
            ST_TAN:
            begin
                if (div_stat.done)
                begin
                    tmag_next  = div_q[23:0];
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                prod_next  = dmag_reg * tmag_reg;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                div_start_next = 1'b1;
                div_a_next     = prod_reg * bodo_pkg::MM_PER_M;
                div_b_next     = {26'd0, wb_eff};
                state_next     = ST_WB;
            end
            ST_WB:
            begin
                if (div_stat.done)
                begin
                    prod_next  = div_q;
                    state_next = ST_MQ1;
                end
            end
            ST_MQ1:
            begin
                acc_next   = prod_reg[63:32] * bodo_pkg::INV2PI_Q32;
                state_next = ST_MQ2;
            end
            ST_MQ2:
            begin
                acc_next   = acc_reg + {32'd0, lo_prod[63:32]};
                state_next = ST_DH;
            end
            ST_DH:
            begin
                dh_next    = (cneg_reg != sneg_reg) ? -$signed(t_lim) : $signed(t_lim);
                state_next = ST_X0;
            end
            ST_X0:
            begin
                cor_start_next = 1'b1;
                cor_phase_next = {head_reg, 16'd0} + dh_reg[32:1];
                cor_x0_next    = dist32 * $signed({1'b0, bodo_pkg::GAIN_Q30});
                state_next     = ST_ROT2;
            end
            ST_ROT2:
            begin
                if (cor_stat.done)
                begin
                    dx_next    = x_dx[63:30];
                    dy_next    = y_dy[63:30];
                    state_next = ST_POSE;
                end
            end
            ST_POSE:
            begin
                if (x_sum > 35'sh0_7FFF_FFFF)
                begin
                    x_next = 32'sh7FFF_FFFF;
                end
                else if (x_sum < -35'sh0_8000_0000)
                begin
                    x_next = 32'sh8000_0000;
                end
                else
                begin
                    x_next = x_sum[31:0];
                end
                if (y_sum > 35'sh0_7FFF_FFFF)
                begin
                    y_next = 32'sh7FFF_FFFF;
                end
                else if (y_sum < -35'sh0_8000_0000)
                begin
                    y_next = 32'sh8000_0000;
                end
                else
                begin
                    y_next = y_sum[31:0];
                end
                head_next  = head_reg + hstep[31:16];
                k_next     = K_VX;
                state_next = ST_SCL;
            end
            ST_SCL:
            begin
                div_start_next = 1'b1;
                div_a_next     = sc_mag;
                div_b_next     = sc_div;
                state_next     = ST_SCQ;
            end
            ST_SCQ:
            begin
                if (div_stat.done && !sc_fin)
                begin
                    sq_next    = div_q[30:0];
                    sr_next    = div_r;
                    state_next = ST_SCM;
                end
            end
            ST_SCM:
            begin
                div_start_next = 1'b1;
                div_a_next     = sr_reg * sc_mul;
                div_b_next     = sc_div;
                qm_next        = sq_reg * sc_mul;
                state_next     = ST_SCR;
            end
            ST_SCR:
            begin
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (sc_fin)
        begin
            case (k_reg)
                K_VX:    vx_next = sc_out;
                K_VY:    vy_next = sc_out;
                default: yr_next = sc_out;
            endcase
            if (k_reg == K_YR)
            begin
                state_next = ST_OUT;
            end
            else
            begin
                k_next     = k_reg + 2'd1;
                state_next = ST_SCL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wb_reg        <= bodo_pkg::WHEELBASE_RST;
            cpm_reg       <= bodo_pkg::CPM_RST;
            gap_reg       <= bodo_pkg::MAX_GAP_RST;
            last_reg      <= '0;
            upd_reg       <= 1'b0;
            k_reg         <= K_VX;
            x_reg         <= '0;
            y_reg         <= '0;
            head_reg      <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            yr_reg        <= '0;
            div_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            upd_reg       <= upd_next;
            k_reg         <= k_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            head_reg      <= head_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            yr_reg        <= yr_next;
            div_start_reg <= div_start_next;
            cor_start_reg <= cor_start_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    bodo_pkg::REG_WHEELBASE: wb_reg  <= cfg_data[13:0];
                    bodo_pkg::REG_CPM:       cpm_reg <= cfg_data[19:0];
                    bodo_pkg::REG_MAX_GAP:   gap_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        cmag_reg      <= cmag_next;
        cneg_reg      <= cneg_next;
        dt_reg        <= dt_next;
        dmag_reg      <= dmag_next;
        sneg_reg      <= sneg_next;
        tmag_reg      <= tmag_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        dh_reg        <= dh_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sq_reg        <= sq_next;
        sr_reg        <= sr_next;
        qm_reg        <= qm_next;
        div_a_reg     <= div_a_next;
        div_b_reg     <= div_b_next;
        cor_phase_reg <= cor_phase_next;
        cor_x0_reg    <= cor_x0_next;
    end

    `BODO_ASSERT_NEXT(a_gap_skip, clk, rst_n, s_tvalid && s_tready && !upd_in, m_tvalid && !m_tuser[0])
    `BODO_ASSERT_SAME(a_div_free, clk, rst_n, div_start_reg, !div_stat.busy)
    `BODO_ASSERT_SAME(a_cor_free, clk, rst_n, cor_start_reg, !cor_stat.busy)
    `BODO_ASSERT_SAME(a_idle_quiet, clk, rst_n, state_reg == ST_IDLE, !div_stat.busy && !cor_stat.busy)

endmodule
`default_nettype wire

@@ rtl/bodo_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on bodo_pkg for widths and the unit status type.
`default_nettype none
module bodo_div
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [bodo_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [bodo_pkg::DIVISOR_W-1:0]     divisor,
    output bodo_pkg::unit_stat_t                    stat,
    output logic      [bodo_pkg::DIVIDEND_W-1:0]    quot,
    output logic      [bodo_pkg::DIVISOR_W-1:0]     rem
);
    localparam int DW = bodo_pkg::DIVIDEND_W;
    localparam int VW = bodo_pkg::DIVISOR_W;
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [DW-1:0] quot_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;

    logic [VW:0]   sh;
    logic [VW:0]   diff;
    logic          fits;
    logic [VW-1:0] rem_step;

    always_comb
    begin
        sh       = {rem_reg, quot_reg[DW-1]};
        diff     = sh - {1'b0, dvs_reg};
        fits     = sh >= {1'b0, dvs_reg};
        rem_step = fits ? diff[VW-1:0] : sh[VW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(DW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quot_reg <= {quot_reg[DW-2:0], fits};
            rem_reg  <= rem_step;
        end
    end

    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;
    assign quot      = quot_reg;
    assign rem       = rem_reg;

endmodule
`default_nettype wire

@@ rtl/bodo_cordic.sv @@
// Iterative rotation-mode CORDIC over 2^-32-turn phases, one step per cycle.
// Depends on bodo_pkg for the arctangent table and the unit status type.
`default_nettype none
module bodo_cordic
#(
    parameter int STEPS = bodo_pkg::CORDIC_STEPS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic        [31:0] phase,
    input  wire logic signed [63:0] x0,
    output bodo_pkg::unit_stat_t    stat,
    output logic signed      [63:0] cs,
    output logic signed      [63:0] sn
);
    localparam int NSTEP = (STEPS < bodo_pkg::TABLE_LEN) ? STEPS : bodo_pkg::TABLE_LEN;
    localparam int IDX_W = $clog2(NSTEP);
    localparam logic signed [33:0] QUARTER = 34'sh0_4000_0000;
    localparam logic signed [33:0] HALF    = 34'sh0_8000_0000;

    logic             run_reg;
    logic             done_reg;
    logic [IDX_W-1:0] idx_reg;
    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    logic signed [33:0] z_reg;
    logic             neg_reg;
    logic signed [63:0] cs_reg;
    logic signed [63:0] sn_reg;

    logic signed [33:0] z_in;
    logic signed [33:0] z_start;
    logic               neg_start;
    logic signed [63:0] ddx;
    logic signed [63:0] ddy;
    logic signed [33:0] at;
    logic signed [63:0] x_new;
    logic signed [63:0] y_new;
    logic signed [33:0] z_new;
    logic               last;

    always_comb
    begin
        z_in      = {{2{phase[31]}}, phase};
        z_start   = z_in;
        neg_start = 1'b0;
        if (z_in > QUARTER)
        begin
            z_start   = z_in - HALF;
            neg_start = 1'b1;
        end
        else if (z_in < -QUARTER)
        begin
            z_start   = z_in + HALF;
            neg_start = 1'b1;
        end
        ddx = y_reg >>> idx_reg;
        ddy = x_reg >>> idx_reg;
        at  = {2'b00, bodo_pkg::atan_turn(5'(idx_reg))};
        if (z_reg >= 0)
        begin
            x_new = x_reg - ddx;
            y_new = y_reg + ddy;
            z_new = z_reg - at;
        end
        else
        begin
            x_new = x_reg + ddx;
            y_new = y_reg - ddy;
            z_new = z_reg + at;
        end
        last = idx_reg == IDX_W'(NSTEP - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                idx_reg <= '0;
            end
            else if (run_reg)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (last)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x0;
            y_reg   <= '0;
            z_reg   <= z_start;
            neg_reg <= neg_start;
        end
        else if (run_reg)
        begin
            x_reg <= x_new;
            y_reg <= y_new;
            z_reg <= z_new;
            if (last)
            begin
                cs_reg <= neg_reg ? -x_new : x_new;
                sn_reg <= neg_reg ? -y_new : y_new;
            end
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign cs        = cs_reg;
    assign sn        = sn_reg;

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for bicycle_odometry_integrator: random and directed wheel reports
// checked against a bit-accurate dead-reckoning predictor in a scoreboard class.
// Depends on bodo_pkg and the RTL of the block.
module testbench;

    localparam int  STEPS     = 16;
    localparam int  FRAC      = 16;
    localparam int  LIMIT     = 2_000_000;
    localparam int  HOLD_OFF  = 3000;
    localparam longint ATAN_TURN [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

    typedef struct {
        bit [62:0]          stamp;
        logic signed [10:0] steer;
        bit                 steer_on;
        logic signed [23:0] speed;
        bit                 speed_on;
    } report_t;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] yaw_rate;
        logic        updated;
    } pose_t;

    class odo_scoreboard;
        bit [63:0] wheelbase, cpm, max_gap, heading, last_stamp;
        longint    x, y, vx, vy, yaw;
        pose_t     pose_q[$];
        int        errors;

        function new();
            wheelbase  = 700;
            cpm        = 33000;
            max_gap    = 10000000;
            heading    = 0;
            last_stamp = 0;
            x = 0; y = 0; vx = 0; vy = 0; yaw = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [bodo_pkg::CFG_IDX_W-1:0] idx, bit [26:0] val);
            if (idx == bodo_pkg::REG_WHEELBASE) wheelbase = val[13:0];
            else if (idx == bodo_pkg::REG_CPM) cpm = val[19:0];
            else if (idx == bodo_pkg::REG_MAX_GAP) max_gap = val;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function bit [63:0] mulq32(bit [63:0] a, bit [63:0] b);
            return (a >> 32) * b + (({32'b0, a[31:0]} * b) >> 32);
        endfunction

        function longint scale_sat(longint v, bit [63:0] mul, bit [63:0] div);
            bit        neg;
            bit [63:0] mag, q, r, res;
            neg = v < 0;
            mag = neg ? 64'(-v) : 64'(v);
            q = mag / div;
            r = mag % div;
            if (q >= 64'h8000_0000) res = 64'h8000_0000;
            else res = q * mul + (r * mul) / div;
            if (neg) return (res >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(res);
            return (res > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(res);
        endfunction

        function void rotate(bit [63:0] phase, longint x0, output longint cs,
                             output longint sn);
            longint zz, xx, yy, ddx, ddy;
            bit     flip;
            zz = longint'({32'b0, phase[31:0]});
            xx = x0;
            yy = 0;
            flip = 0;
            if (zz >= 64'sh8000_0000) zz -= 64'sh1_0000_0000;
            if (zz > 64'sh4000_0000)
            begin
                zz -= 64'sh8000_0000;
                flip = 1;
            end
            else if (zz < -64'sh4000_0000)
            begin
                zz += 64'sh8000_0000;
                flip = 1;
            end
            for (int i = 0; i < STEPS && i < 24; i++)
            begin
                ddx = yy >>> i;
                ddy = xx >>> i;
                if (zz >= 0)
                begin
                    xx -= ddx; yy += ddy; zz -= ATAN_TURN[i];
                end
                else
                begin
                    xx += ddx; yy -= ddy; zz += ATAN_TURN[i];
                end
            end
            if (flip)
            begin
                xx = -xx; yy = -yy;
            end
            cs = xx;
            sn = yy;
        endfunction

        function void note_report(report_t rep);
            bit        upd;
            bit [63:0] stamp, dt, div_cpm, wb, dmag, amag, ph, tmag, tt, mid;
            longint    ang, cnt, acnt, dist_m, dh, c, s, dx, dy;
            pose_t     p;
            stamp = {1'b0, rep.stamp};
            upd = stamp > last_stamp && (stamp - last_stamp) < max_gap;
            if (upd)
            begin
                dt = stamp - last_stamp;
                div_cpm = cpm ? cpm : 1;
                wb = wheelbase ? wheelbase : 1;
                ang = rep.steer_on ? longint'(rep.steer) : 0;
                cnt = rep.speed_on ? longint'(rep.speed) : 0;
                acnt = cnt < 0 ? -cnt : cnt;
                dmag = 64'(acnt) << FRAC;
                dh = 0;
                if (ang > 850) ang = 850;
                if (ang < -850) ang = -850;
                dmag = (dmag + div_cpm / 2) / div_cpm;
                if (dmag > 64'h7FFF_FFFF) dmag = 64'h7FFF_FFFF;
                dist_m = cnt < 0 ? -longint'(dmag) : longint'(dmag);
                if (ang != 0 && dmag != 0)
                begin
                    amag = 64'(ang < 0 ? -ang : ang);
                    ph = ((amag << 32) + 1800) / 3600;
                    rotate(ang < 0 ? -ph : ph, 64'sd1 << 30, c, s);
                    if (c < 1) c = 1;
                    tmag = (64'(s < 0 ? -s : s) << 16) / 64'(c);
                    tt = mulq32(dmag * tmag * 1000 / wb, 64'd683565276);
                    tt = tt >> (FRAC - 16);
                    if (tt > 64'h4000_0000_0000_0000) tt = 64'h4000_0000_0000_0000;
                    dh = ((cnt < 0) != (s < 0)) ? -longint'(tt) : longint'(tt);
                end
                mid = ((heading << 16) + 64'(dh >>> 1)) & 64'hFFFF_FFFF;
                rotate(mid, dist_m * 64'sd652032874, c, s);
                dx = (c + (64'sd1 << 29)) >>> 30;
                dy = (s + (64'sd1 << 29)) >>> 30;
                x = sat32(x + dx);
                y = sat32(y + dy);
                heading = (heading + 64'((dh + 32768) >>> 16)) & 64'hFFFF;
                vx = scale_sat(dx, 1000000, dt);
                vy = scale_sat(dy, 1000000, dt);
                yaw = scale_sat(dh, 15625, dt * 1024);
            end
            last_stamp = stamp;
            p.pos_x = x[31:0];
            p.pos_y = y[31:0];
            p.heading = heading[15:0];
            p.vel_x = vx[31:0];
            p.vel_y = vy[31:0];
            p.yaw_rate = yaw[31:0];
            p.updated = upd;
            pose_q.push_back(p);
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_pose(pose_t act);
            pose_t e;
            if (pose_q.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = pose_q.pop_front();
            compare("pos_x", e.pos_x, act.pos_x);
            compare("pos_y", e.pos_y, act.pos_y);
            compare("heading_angle", 32'(e.heading), 32'(act.heading));
            compare("vel_x", e.vel_x, act.vel_x);
            compare("vel_y", e.vel_y, act.vel_y);
            compare("yaw_rate", e.yaw_rate, act.yaw_rate);
            compare("updated", 32'(e.updated), 32'(act.updated));
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [bodo_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [bodo_pkg::IN_USER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [bodo_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [bodo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bodo_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    odo_scoreboard sb = new();
    bit        hold_req = 0;
    int        cycles = 0;
    int        burst_left = 0;
    bit [62:0] cur_stamp = 0;

    bicycle_odometry_integrator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pose_t act;
        if (rst_n && m_tvalid && m_tready)
        begin
            act.pos_x = m_tdata[31:0];
            act.pos_y = m_tdata[63:32];
            act.heading = m_tdata[79:64];
            act.vel_x = m_tdata[111:80];
            act.vel_y = m_tdata[143:112];
            act.yaw_rate = m_tdata[175:144];
            act.updated = m_tuser[0];
            sb.check_pose(act);
        end
    end

    initial
    begin
        int mode;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                m_tready <= 0;
                repeat (HOLD_OFF) @(negedge clk);
            end
            else
            begin
                if (cycles % 64 == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: m_tready <= 1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= (cycles % 5 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_report(report_t rep);
        @(negedge clk);
        s_tvalid <= 1;
        s_tdata <= {6'b0, rep.speed, rep.steer, rep.stamp};
        s_tuser <= {rep.speed_on, rep.steer_on};
        do @(posedge clk); while (!s_tready);
        sb.note_report(rep);
    endtask

    task automatic idle_gap(int n);
        @(negedge clk);
        s_tvalid <= 0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic offer(report_t rep);
        send_report(rep);
        if (burst_left == 0)
        begin
            idle_gap($urandom_range(1, 25));
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 10);
        end
        else
            burst_left--;
    endtask

    task automatic write_reg(logic [bodo_pkg::CFG_IDX_W-1:0] idx, bit [26:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic reconfigure(bit [26:0] wb, bit [26:0] cpm, bit [26:0] gap);
        idle_gap(1);
        wait (sb.pose_q.size() == 0);
        write_reg(bodo_pkg::REG_WHEELBASE, wb);
        write_reg(bodo_pkg::REG_CPM, cpm);
        write_reg(bodo_pkg::REG_MAX_GAP, gap);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic report_t make_report(bit [62:0] stamp, int steer, bit s_on,
                                            int speed, bit v_on);
        report_t r;
        r.stamp = stamp;
        r.steer = steer[10:0];
        r.steer_on = s_on;
        r.speed = speed[23:0];
        r.speed_on = v_on;
        return r;
    endfunction

    function automatic report_t random_report();
        report_t   r;
        bit [63:0] dt;
        int        k;
        k = $urandom_range(0, 99);
        if (k < 76)
        begin
            dt = (sb.max_gap > 1) ? $urandom_range(1, (sb.max_gap - 1 > 100000) ?
                  100000 : int'(sb.max_gap - 1)) : 1;
            cur_stamp = cur_stamp + dt[62:0];
        end
        else if (k < 80) cur_stamp = cur_stamp + sb.max_gap[62:0] - 1;
        else if (k < 84) cur_stamp = cur_stamp + sb.max_gap[62:0];
        else if (k < 88) cur_stamp = cur_stamp;
        else if (k < 93) cur_stamp = cur_stamp - $urandom_range(1, 1000);
        else cur_stamp = 63'({$urandom, $urandom});
        r.stamp = cur_stamp;
        r.steer = ($urandom_range(0, 4) == 0) ? 11'($urandom) :
                  11'($urandom_range(0, 1700) - 850);
        r.speed = ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                  24'($urandom_range(0, 20000) - 10000);
        r.steer_on = ($urandom_range(0, 4) != 0);
        r.speed_on = ($urandom_range(0, 4) != 0);
        return r;
    endfunction

    initial
    begin
        bit [26:0] wb_set  [6] = '{700, 100, 10000, 0, 16383, 2500};
        bit [26:0] cpm_set [6] = '{33000, 1, 1000000, 0, 1048575, 500};
        bit [26:0] gap_set [6] = '{10000000, 27'h7FFFFFF, 1, 0, 50000, 100000000};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        offer(make_report(5000, 0, 1, 1000, 1));
        offer(make_report(10000, 850, 1, 33000, 1));
        offer(make_report(20000, -850, 1, -33000, 1));
        offer(make_report(30000, 1023, 1, 8388607, 1));
        offer(make_report(40000, -1024, 1, -8388608, 1));
        offer(make_report(50000, 500, 0, 1000, 1));
        offer(make_report(60000, 500, 1, 1000, 0));
        offer(make_report(70000, 300, 1, 0, 1));
        offer(make_report(70000, 300, 1, 500, 1));
        offer(make_report(65000, 300, 1, 500, 1));
        offer(make_report(65000 + 9999999, -200, 1, 700, 1));
        offer(make_report(65000 + 9999999 + 10000000, -200, 1, 700, 1));
        offer(make_report(63'h7FFF_FFFF_FFFF_FFFF, 100, 1, 100, 1));
        offer(make_report(0, 100, 1, 100, 1));
        offer(make_report(1, 100, 1, 100, 1));
        offer(make_report(63'h2AAA_AAAA_AAAA_AAAA, 11'h555, 1, 24'h555555, 1));
        offer(make_report(63'h2AAA_AAAA_AAAA_AAAB, 11'h2AA, 1, 24'hAAAAAA, 1));
        cur_stamp = 63'h2AAA_AAAA_AAAA_AAAB;

        for (int ph = 0; ph < 6; ph++)
        begin
            reconfigure(wb_set[ph], cpm_set[ph], gap_set[ph]);
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < 72; n++) offer(random_report());
        end

        idle_gap(1);
        wait (sb.pose_q.size() == 0);
        repeat (800) @(posedge clk);
        if (sb.errors == 0 && sb.pose_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/bodo_pkg.sv
rtl/bodo_div.sv
rtl/bodo_cordic.sv
rtl/bicycle_odometry_integrator.sv
dv/testbench.sv
